/* src/ostc_pkg.sv */
// Shared types and constants for the order-statistic count tree core.
// Holds the command and result beat layouts and the opcode and status codes.
// Depends on nothing.
package ostc_pkg;

    // Default number of positions and fixed field widths.
    localparam int MAX_POSITIONS_DFLT = 1024;
    localparam int SIZE_RESET         = 1024;
    localparam int VALUE_BITS         = 32;
    localparam int POS_BITS           = 10;
    localparam int RANK_BITS          = 11;
    localparam int CFG_BITS           = 11;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_BUILD  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_QUERY  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_RANK = 2'd1,
        ST_POS  = 2'd2
    } status_t;

    // One command beat.
    typedef struct packed {
        opcode_t                opcode;
        logic [POS_BITS-1:0]    position;
        logic [VALUE_BITS-1:0]  item_value;
        logic [RANK_BITS-1:0]   rank;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic [VALUE_BITS-1:0]  found_value;
        status_t                status;
    } res_t;

endpackage

/* src/order_statistic_count_tree_core.sv */
// Order-statistic count tree: value store plus a heap-ordered count tree in memory.
// Depends on ostc_pkg for the beat layouts, codes and default sizes.
//
// Channel | Direction | Handshake            | Payload
// cmd     | in        | cmd_valid/cmd_stall  | ostc_pkg::cmd_t
// res     | out       | res_valid/res_stall  | ostc_pkg::res_t
// cfg     | in        | cfg_we               | cfg_wdata (size_in_use)
//
// A query descends one tree level a cycle through the one count read port, and its last
// step reads the value store; a remove climbs from the leaf to the root the same way.
// Load and commands rejected at accept go straight to the result; removing an absent position stops at its leaf.
// Build rewrites every tree node, one node a cycle.
// After reset and after every size write, a clearing pass zeroes the tree while
// cmd_stall stays high; a stalled result waits in the output register.
module order_statistic_count_tree_core #(
    parameter int MAX_POSITIONS = ostc_pkg::MAX_POSITIONS_DFLT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_stall,
    input  ostc_pkg::cmd_t                  cmd,
    output logic                            res_valid,
    input  logic                            res_stall,
    output ostc_pkg::res_t                  res,
    input  logic                            cfg_we,
    input  logic [ostc_pkg::CFG_BITS-1:0]   cfg_wdata
);

    // Tree geometry: 2^ADDR_BITS leaves, nodes 1 .. 2*2^ADDR_BITS-1.
    localparam int ADDR_BITS = $clog2(MAX_POSITIONS);
    localparam int CNT_BITS  = ADDR_BITS + 1;
    localparam int LVL_BITS  = $clog2(ADDR_BITS + 1);
    localparam int NODES     = 2 << ADDR_BITS;
    localparam int SIZE_INIT = (MAX_POSITIONS > ostc_pkg::SIZE_RESET) ?
                               ostc_pkg::SIZE_RESET : MAX_POSITIONS;

    typedef enum logic [5:0] {
        S_SWEEP  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_WALK   = 6'b000100,
        S_FETCH  = 6'b001000,
        S_REMOVE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CNT_BITS-1:0]            size_reg, size_next;
    logic [CNT_BITS-1:0]            root_reg, root_next;
    logic [CNT_BITS-1:0]            node_reg, node_next;
    logic [CNT_BITS-1:0]            k_reg, k_next;
    logic [LVL_BITS-1:0]            lvl_reg, lvl_next;
    logic                           sweep_fill_reg, sweep_fill_next;
    logic [LVL_BITS-1:0]            sweep_d_reg, sweep_d_next;
    logic [ADDR_BITS-1:0]           sweep_j_reg, sweep_j_next;
    ostc_pkg::res_t                 pend_reg, pend_next;
    logic                           res_valid_reg, res_valid_next;
    ostc_pkg::res_t                 res_data_reg, res_data_next;

    // Memories and their registered read data.
    logic [CNT_BITS-1:0]                cnt_mem [0:NODES-1];
    logic [ostc_pkg::VALUE_BITS-1:0]    val_mem [0:MAX_POSITIONS-1];
    logic [CNT_BITS-1:0]                cnt_rd_reg;
    logic [ostc_pkg::VALUE_BITS-1:0]    val_rd_reg;

    logic                           cnt_re, cnt_we;
    logic [CNT_BITS-1:0]            cnt_raddr, cnt_waddr, cnt_wdata;
    logic                           val_re, val_we;
    logic [ADDR_BITS-1:0]           val_addr;

    logic                           cmd_accept;
    logic                           pos_ok;
    logic [CNT_BITS-1:0]            leaf_addr;
    logic                           go_left;
    logic [CNT_BITS-1:0]            child;
    logic [LVL_BITS-1:0]            sweep_shift;
    logic [CNT_BITS-1:0]            sweep_base;
    logic [CNT_BITS-1:0]            sweep_span;
    logic [CNT_BITS-1:0]            sweep_left;
    logic [CNT_BITS-1:0]            fill_cnt;
    logic [CNT_BITS-1:0]            sweep_node;
    logic                           sweep_level_end;
    logic                           sweep_last;
    logic [CNT_BITS-1:0]            size_cfg;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign cmd_accept = cmd_valid && (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;
    assign res        = res_data_reg;

    // Position check and leaf node of the commanded position.
    assign pos_ok    = 32'(cmd.position) < 32'(size_reg);
    assign leaf_addr = {1'b1, ADDR_BITS'(cmd.position)};

    // One descent step: left child count against the remaining rank.
    assign go_left = cnt_rd_reg >= k_reg;
    assign child   = {node_reg[ADDR_BITS-1:0], ~go_left};

    // Built count of the swept node: positions in use within its span.
    assign sweep_shift     = LVL_BITS'(ADDR_BITS) - sweep_d_reg;
    assign sweep_base      = CNT_BITS'(sweep_j_reg) << sweep_shift;
    assign sweep_span      = CNT_BITS'(1) << sweep_shift;
    assign sweep_left      = size_reg - sweep_base;
    assign fill_cnt        = (size_reg > sweep_base) ?
                             ((sweep_left < sweep_span) ? sweep_left : sweep_span) :
                             '0;
    assign sweep_node      = (CNT_BITS'(1) << sweep_d_reg) | CNT_BITS'(sweep_j_reg);
    assign sweep_level_end = (sweep_j_reg == ({ADDR_BITS{1'b1}} >> sweep_shift));
    assign sweep_last      = sweep_level_end && (sweep_d_reg == LVL_BITS'(ADDR_BITS));

    // Size write: zero acts as one, anything above the store depth is clamped.
    assign size_cfg = (cfg_wdata == '0) ? CNT_BITS'(1) :
                      ((32'(cfg_wdata) > MAX_POSITIONS) ? CNT_BITS'(MAX_POSITIONS) :
                       CNT_BITS'(cfg_wdata));

    // Control and memory access sequencing.
    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        root_next       = root_reg;
        node_next       = node_reg;
        k_next          = k_reg;
        lvl_next        = lvl_reg;
        sweep_fill_next = sweep_fill_reg;
        sweep_d_next    = sweep_d_reg;
        sweep_j_next    = sweep_j_reg;
        pend_next       = pend_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_data_next   = res_data_reg;

        cnt_re    = 1'b0;
        cnt_raddr = node_reg;
        cnt_we    = 1'b0;
        cnt_waddr = node_reg;
        cnt_wdata = '0;
        val_re    = 1'b0;
        val_we    = 1'b0;
        val_addr  = ADDR_BITS'(cmd.position);

        unique case (state_reg)
            S_SWEEP:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = sweep_node;
                cnt_wdata = sweep_fill_reg ? fill_cnt : '0;
                if (sweep_last)
                begin
                    pend_next  = '{found_value: '0, status: ostc_pkg::ST_OK};
                    state_next = sweep_fill_reg ? S_DONE : S_IDLE;
                end
                else if (sweep_level_end)
                begin
                    sweep_d_next = sweep_d_reg + LVL_BITS'(1);
                    sweep_j_next = '0;
                end
                else
                begin
                    sweep_j_next = sweep_j_reg + ADDR_BITS'(1);
                end
            end

            S_IDLE:
            begin
                if (cmd_accept)
                begin
                    pend_next  = '{found_value: '0, status: ostc_pkg::ST_OK};
                    state_next = S_DONE;
                    unique case (cmd.opcode)
                        ostc_pkg::OP_LOAD:
                        begin
                            if (pos_ok)
                                val_we = 1'b1;
                            else
                                pend_next.status = ostc_pkg::ST_POS;
                        end
                        ostc_pkg::OP_BUILD:
                        begin
                            sweep_fill_next = 1'b1;
                            sweep_d_next    = '0;
                            sweep_j_next    = '0;
                            root_next       = size_reg;
                            state_next      = S_SWEEP;
                        end
                        ostc_pkg::OP_REMOVE:
                        begin
                            if (pos_ok)
                            begin
                                cnt_re     = 1'b1;
                                cnt_raddr  = leaf_addr;
                                node_next  = leaf_addr;
                                state_next = S_REMOVE;
                            end
                            else
                            begin
                                pend_next.status = ostc_pkg::ST_POS;
                            end
                        end
                        ostc_pkg::OP_QUERY:
                        begin
                            if ((cmd.rank == '0) || (32'(cmd.rank) > 32'(root_reg)))
                            begin
                                pend_next.status = ostc_pkg::ST_RANK;
                            end
                            else
                            begin
                                cnt_re     = 1'b1;
                                cnt_raddr  = CNT_BITS'(2);
                                node_next  = CNT_BITS'(1);
                                k_next     = CNT_BITS'(cmd.rank);
                                lvl_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end

            // Descend one level a cycle; the last step addresses the value store.
            S_WALK:
            begin
                if (!go_left)
                    k_next = k_reg - cnt_rd_reg;
                if (lvl_reg == LVL_BITS'(ADDR_BITS - 1))
                begin
                    val_re     = 1'b1;
                    val_addr   = child[ADDR_BITS-1:0];
                    state_next = S_FETCH;
                end
                else
                begin
                    cnt_re     = 1'b1;
                    cnt_raddr  = {child[ADDR_BITS-1:0], 1'b0};
                    node_next  = child;
                    lvl_next   = lvl_reg + LVL_BITS'(1);
                end
            end

            S_FETCH:
            begin
                pend_next  = '{found_value: val_rd_reg, status: ostc_pkg::ST_OK};
                state_next = S_DONE;
            end

            // Walk from the leaf to the root, decrementing each count on the way; a zero leaf count rejects the remove.
            S_REMOVE:
            begin
                if (cnt_rd_reg == '0)
                begin
                    pend_next.status = ostc_pkg::ST_POS;
                    state_next       = S_DONE;
                end
                else
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = node_reg;
                    cnt_wdata = cnt_rd_reg - CNT_BITS'(1);
                    if (node_reg == CNT_BITS'(1))
                    begin
                        root_next  = cnt_rd_reg - CNT_BITS'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_re    = 1'b1;
                        cnt_raddr = node_reg >> 1;
                        node_next = node_reg >> 1;
                    end
                end
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_SWEEP;
            end
        endcase

        // A size write clears the tree and restarts the clearing pass.
        if (cfg_we)
        begin
            size_next       = size_cfg;
            root_next       = '0;
            sweep_fill_next = 1'b0;
            sweep_d_next    = '0;
            sweep_j_next    = '0;
            state_next      = S_SWEEP;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            size_reg       <= CNT_BITS'(SIZE_INIT);
            root_reg       <= '0;
            sweep_fill_reg <= 1'b0;
            sweep_d_reg    <= '0;
            sweep_j_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            root_reg       <= root_next;
            sweep_fill_reg <= sweep_fill_next;
            sweep_d_reg    <= sweep_d_next;
            sweep_j_reg    <= sweep_j_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // Payload and walk registers.
    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        k_reg        <= k_next;
        lvl_reg      <= lvl_next;
        pend_reg     <= pend_next;
        res_data_reg <= res_data_next;
    end

    // Count tree memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re)
            cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    // Value store: single port with registered read data.
    always_ff @(posedge clk)
    begin
        if (val_we)
            val_mem[val_addr] <= cmd.item_value;
        if (val_re)
            val_rd_reg <= val_mem[val_addr];
    end

`ifndef SYNTHESIS
    // The present count never exceeds the number of positions in use.
    a_root_le_size: assert property (@(posedge clk) disable iff (!rst_n)
        root_reg <= size_reg)
        else $error("present count above size in use");

    // Every accepted command takes the block out of the idle state in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> (state_reg != S_IDLE))
        else $error("command accepted without leaving idle");

    // The remaining rank during a descent is never zero.
    a_walk_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (k_reg != '0))
        else $error("descent with zero remaining rank");

    // Ancestors of a present leaf always hold a nonzero count.
    a_remove_ancestor: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_REMOVE) && !node_reg[ADDR_BITS]) |-> (cnt_rd_reg != '0))
        else $error("zero count above a present leaf");

    // The clearing and build pass never runs past the leaf level.
    a_sweep_level: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (32'(sweep_d_reg) <= ADDR_BITS))
        else $error("sweep level beyond the leaves");
`endif

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for order_statistic_count_tree_core: directed and random command
// beats, with a presence-array predictor of the found values and status codes.
// Depends on ostc_pkg and the core RTL.
module testbench;

    localparam int POSITIONS    = ostc_pkg::MAX_POSITIONS_DFLT;
    localparam int CFG_W        = ostc_pkg::CFG_BITS;
    localparam int POS_W        = ostc_pkg::POS_BITS;
    localparam int RANK_W       = ostc_pkg::RANK_BITS;
    localparam int VAL_W        = ostc_pkg::VALUE_BITS;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_stall;
    ostc_pkg::cmd_t   cmd       = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    ostc_pkg::res_t   res;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    order_statistic_count_tree_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // Shadow of the block: size in use, presence per position and the value store.
    int unsigned      span          = ostc_pkg::SIZE_RESET;
    bit               present [POSITIONS];
    logic [VAL_W-1:0] stored [POSITIONS];
    int unsigned      present_total = 0;

    // Stimulus-side copy of size and presence, and the positions loaded so far.
    int unsigned      gen_span      = ostc_pkg::SIZE_RESET;
    bit               gen_present [POSITIONS];
    bit               gen_written [POSITIONS];
    int unsigned      gen_total     = 0;

    ostc_pkg::res_t expected_res [$];
    ostc_pkg::cmd_t pending_cmds [$];
    int   mismatches          = 0;
    int   quiet_cycles        = 0;
    logic cmd_beat_taken      = 1'b0;
    bit   gaps_on             = 1'b0;
    bit   stalls_on           = 1'b0;
    int   cmd_gap             = 0;
    int   stall_left          = 0;
    int   free_left           = 0;

    // A size write clamps to 1..POSITIONS and empties the tree; stored values survive.
    function automatic void resize_tree(logic [CFG_W-1:0] wdata);
        int unsigned v;
        int          i;
        v = 32'(wdata);
        if (v == 0)
            v = 1;
        if (v > POSITIONS)
            v = POSITIONS;
        span = v;
        for (i = 0; i < POSITIONS; i++)
            present[i] = 1'b0;
        present_total = 0;
    endfunction

    // Applies one command beat to the shadow and returns the result beat it should give.
    function automatic ostc_pkg::res_t predict_beat(ostc_pkg::cmd_t c);
        ostc_pkg::res_t r;
        int unsigned    seen;
        int             i;
        r.found_value = '0;
        r.status      = ostc_pkg::ST_OK;
        case (c.opcode)
            ostc_pkg::OP_LOAD:
            begin
                if (c.position >= span)
                    r.status = ostc_pkg::ST_POS;
                else
                    stored[c.position] = c.item_value;
            end
            ostc_pkg::OP_BUILD:
            begin
                for (i = 0; i < POSITIONS; i++)
                    present[i] = (i < span);
                present_total = span;
            end
            ostc_pkg::OP_REMOVE:
            begin
                if (c.position >= span || !present[c.position])
                    r.status = ostc_pkg::ST_POS;
                else
                begin
                    present[c.position] = 1'b0;
                    present_total--;
                end
            end
            ostc_pkg::OP_QUERY:
            begin
                if (c.rank == 0 || c.rank > present_total)
                    r.status = ostc_pkg::ST_RANK;
                else
                begin
                    // Walk positions in order until the rank-th present one.
                    seen = 0;
                    for (i = 0; i < span; i++)
                    begin
                        if (present[i])
                        begin
                            seen++;
                            if (seen == c.rank)
                            begin
                                r.found_value = stored[i];
                                break;
                            end
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Gap lengths: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Appends one command beat to the stimulus queue.
    function automatic void enqueue_beat(ostc_pkg::opcode_t op, int unsigned pos,
                                         logic [VAL_W-1:0] val, int unsigned rank);
        ostc_pkg::cmd_t c;
        c.opcode     = op;
        c.position   = POS_W'(pos);
        c.item_value = val;
        c.rank       = RANK_W'(rank);
        pending_cmds = {pending_cmds, c};
    endfunction

    // Queues one beat and follows it on the stimulus-side copy. A query that will land
    // on a position never loaded gets a load of that position queued just before it.
    function automatic void queue_beat(ostc_pkg::opcode_t op, int unsigned pos,
                                       logic [VAL_W-1:0] val, int unsigned rank);
        int unsigned seen;
        int unsigned target;
        bit          hit;
        int          i;
        case (op)
            ostc_pkg::OP_LOAD:
            begin
                if (pos < gen_span)
                    gen_written[pos] = 1'b1;
            end
            ostc_pkg::OP_BUILD:
            begin
                for (i = 0; i < POSITIONS; i++)
                    gen_present[i] = (i < gen_span);
                gen_total = gen_span;
            end
            ostc_pkg::OP_REMOVE:
            begin
                if (pos < gen_span && gen_present[pos])
                begin
                    gen_present[pos] = 1'b0;
                    gen_total--;
                end
            end
            ostc_pkg::OP_QUERY:
            begin
                if (rank != 0 && rank <= gen_total)
                begin
                    seen   = 0;
                    target = 0;
                    hit    = 1'b0;
                    for (i = 0; i < gen_span && !hit; i++)
                    begin
                        if (gen_present[i])
                        begin
                            seen++;
                            if (seen == rank)
                            begin
                                target = i;
                                hit    = 1'b1;
                            end
                        end
                    end
                    if (hit && !gen_written[target])
                    begin
                        enqueue_beat(ostc_pkg::OP_LOAD, target, $urandom(),
                                     $urandom_range(0, 2047));
                        gen_written[target] = 1'b1;
                    end
                end
            end
        endcase
        enqueue_beat(op, pos, val, rank);
    endfunction

    // Mostly in range, sometimes anywhere in the field.
    function automatic int unsigned pick_position();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(0, gen_span - 1);
        return $urandom_range(0, POSITIONS - 1);
    endfunction

    // Mostly ranks that are present; the rest probe zero and the upper edge.
    function automatic int unsigned pick_rank();
        int r;
        r = $urandom_range(0, 99);
        if (gen_total > 0 && r < 80)
            return $urandom_range(1, gen_total);
        if (r < 86)
            return 0;
        if (r < 94)
            return $urandom_range(1, gen_span + 1);
        return $urandom_range(0, 2047);
    endfunction

    function automatic void queue_random(int count);
        int k;
        int r;
        for (k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4 || (gen_total == 0 && r < 50))
            begin
                // Refill the tree, most often once it has run empty.
                queue_beat(ostc_pkg::OP_BUILD, $urandom_range(0, POSITIONS - 1), $urandom(),
                           $urandom_range(0, 2047));
            end
            else if (r < 26)
                queue_beat(ostc_pkg::OP_LOAD, pick_position(), $urandom(),
                           $urandom_range(0, 2047));
            else if (r < 60)
                queue_beat(ostc_pkg::OP_REMOVE, pick_position(), $urandom(),
                           $urandom_range(0, 2047));
            else
                queue_beat(ostc_pkg::OP_QUERY, $urandom_range(0, POSITIONS - 1), $urandom(),
                           pick_rank());
        end
    endfunction

    // Idle means every queued beat was taken and every result has come back.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_res.size() != 0);
    endtask

    task automatic write_size(logic [CFG_W-1:0] v);
        int i;
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        resize_tree(v);
        gen_span  = span;
        gen_total = 0;
        for (i = 0; i < POSITIONS; i++)
            gen_present[i] = 1'b0;
    endtask

    // Each accepted command beat gets its expected result beat.
    always @(posedge clk)
    begin
        cmd_beat_taken <= cmd_valid && !cmd_stall;
        if (rst_n && cmd_valid && !cmd_stall)
            expected_res = {expected_res, predict_beat(cmd)};
    end

    // Result beats are checked in order against the oldest expectation.
    always @(posedge clk)
    begin
        ostc_pkg::res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: found_value %h status %0d",
                             res.found_value, res.status);
            end
            else
            begin
                want = expected_res.pop_front();
                if (res.found_value !== want.found_value || res.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result mismatch: expected %h status %0d, got %h status %0d",
                                 want.found_value, want.status,
                                 res.found_value, res.status);
                end
            end
        end
    end

    // Command driver: next beat after a taken one, with optional gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_beat_taken))
        begin
            if (cmd_gap > 0)
            begin
                cmd_valid <= 1'b0;
                cmd_gap   <= cmd_gap - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
                cmd_gap   <= gaps_on ? pick_gap() : 0;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // Result stall: alternating stall and free stretches of random length.
    always @(negedge clk)
    begin
        if (!stalls_on)
            res_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            res_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (free_left > 0)
        begin
            res_stall <= 1'b0;
            free_left <= free_left - 1;
        end
        else
        begin
            res_stall  <= 1'b0;
            stall_left <= pick_gap();
            free_left  <= $urandom_range(0, 8);
        end
    end

    // Watchdog on cycles with no beat accepted on either channel.
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial
    begin
        int          p;
        int unsigned plan_size [11] = '{0, 2, 3, 5, 16, 2047, 1, 0, 1500, 1024, 0};
        int          plan_beats [11] = '{40, 50, 50, 50, 60, 60, 25, 70, 50, 50, 60};

        plan_size[7]  = $urandom_range(6, 200);
        plan_size[10] = $urandom_range(1, POSITIONS);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset size: an empty tree rejects queries and removes.
        gaps_on   = ($urandom_range(0, 1) != 0);
        stalls_on = ($urandom_range(0, 1) != 0);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, 0);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, 1);
        queue_beat(ostc_pkg::OP_REMOVE, 5, 0, 0);

        // Extreme values at both ends of the store.
        queue_beat(ostc_pkg::OP_LOAD, 0, '0, 0);
        queue_beat(ostc_pkg::OP_LOAD, POSITIONS - 1, '1, 0);

        // Full tree: rank edges, double remove, removal at both ends, rebuild.
        queue_beat(ostc_pkg::OP_BUILD, 0, 0, 0);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, 1);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, POSITIONS);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, POSITIONS + 1);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, 2047);
        queue_beat(ostc_pkg::OP_REMOVE, 0, 0, 0);
        queue_beat(ostc_pkg::OP_REMOVE, 0, 0, 0);
        queue_beat(ostc_pkg::OP_REMOVE, POSITIONS - 1, 0, 0);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, 1);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, POSITIONS - 2);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, POSITIONS - 1);
        queue_beat(ostc_pkg::OP_BUILD, 0, 0, 0);
        queue_beat(ostc_pkg::OP_LOAD, POSITIONS - 1, $urandom(), 0);
        queue_beat(ostc_pkg::OP_QUERY, 0, 0, POSITIONS);
        queue_random(60);
        wait_idle();

        // Later phases each start from a size write, so the tree begins empty.
        for (p = 0; p < 11; p++)
        begin
            write_size(CFG_W'(plan_size[p]));
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            @(posedge clk);
            if (p == 0)
            begin
                // Single position: out-of-range load and remove, then one-entry tree.
                queue_beat(ostc_pkg::OP_LOAD, 1, $urandom(), 0);
                queue_beat(ostc_pkg::OP_REMOVE, POSITIONS - 1, 0, 0);
                queue_beat(ostc_pkg::OP_QUERY, 0, 0, 1);
                queue_beat(ostc_pkg::OP_BUILD, 0, 0, 0);
                queue_beat(ostc_pkg::OP_QUERY, 0, 0, 1);
                queue_beat(ostc_pkg::OP_QUERY, 0, 0, 2);
                queue_beat(ostc_pkg::OP_REMOVE, 0, 0, 0);
                queue_beat(ostc_pkg::OP_REMOVE, 0, 0, 0);
            end
            queue_random(plan_beats[p]);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_res.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
